FILE: rtl/core/ffca_pkg.sv
// shared constants, codes and item types of the first-fit chunk allocator
package ffca_pkg;

    localparam int PAGE_BYTES  = 4096;
    localparam int CHUNK_BYTES = 256;
    localparam int PAGES       = 4;

    localparam int CPP         = PAGE_BYTES / CHUNK_BYTES;
    localparam int TOTAL       = PAGES * CPP;
    localparam int ARENA_BYTES = PAGES * PAGE_BYTES;
    localparam int IDX_W       = $clog2(TOTAL);
    localparam int CPP_W       = $clog2(CPP);
    localparam int CHUNK_SHIFT = $clog2(CHUNK_BYTES);
    localparam int LEN_W       = 5;
    localparam int OP_W        = 14;
    localparam int ST_W        = 2;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD_SIZE = 2'd1;
    localparam logic [ST_W-1:0] ST_NO_ROOM  = 2'd2;
    localparam logic [ST_W-1:0] ST_FREE_REL = 2'd3;

    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    typedef struct packed {
        logic            req_type;
        logic [OP_W-1:0] operand;
    } t_req;

    typedef struct packed {
        logic [ST_W-1:0] status;
        logic [OP_W-1:0] block_addr;
    } t_rsp;

endpackage

FILE: rtl/core/ffca_ram.sv
// generic single write port ram with registered read
module ffca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/first_fit_chunk_allocator.sv
// first-fit chunk allocator: length table in ram, sequential scan and mark
//
//  channel   | ports                       | handshake
//  request   | start, i_req (t_req)        | taken when start high and busy low
//  response  | o_strobe, o_rsp (t_rsp)     | shown for one cycle, no back-pressure
//
// allocate scans one table entry per cycle through the single ram read port,
// then marks the run one entry per cycle.
// release checks the addressed entry, then clears the run up to its stored length
// or the page end; a bad size or an address beyond the arena is answered from idle.
// reset clears the per-entry valid flops; no clearing pass is needed.
// busy stays high until the response strobe, which lands as busy falls.
module first_fit_chunk_allocator
    import ffca_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_strobe,
    output t_rsp o_rsp
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_WRITE = 5'b00100,
        S_RCHK  = 5'b01000,
        S_FREE  = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic               r_done, n_done;
    t_rsp               r_rsp, n_rsp;
    logic [LEN_W-1:0]   r_need, n_need;
    logic [LEN_W-1:0]   r_run, n_run;
    logic [IDX_W-1:0]   r_chk_idx, n_chk_idx;
    logic [IDX_W-1:0]   r_widx, n_widx;
    logic [LEN_W-1:0]   r_wcnt, n_wcnt;
    logic [TOTAL-1:0]   r_valid;
    logic               r_vq;

    logic               accept;
    logic [IDX_W-1:0]   rd_addr;
    logic [LEN_W-1:0]   ram_q;
    logic [LEN_W-1:0]   len_eff;
    logic               ram_we;
    logic               set_valid, clr_valid;
    logic               bad_size, rel_out;
    logic [IDX_W-1:0]   rel_idx;
    logic               chunk_free;
    logic [LEN_W-1:0]   run_next;
    logic [IDX_W-1:0]   run_start;

    assign accept   = start && (r_state == S_IDLE);
    assign bad_size = (i_req.operand == '0)
                   || (i_req.operand[CHUNK_SHIFT-1:0] != '0)
                   || (32'(i_req.operand) > PAGE_BYTES);
    assign rel_out  = 32'(i_req.operand) >= ARENA_BYTES;
    assign rel_idx  = IDX_W'(i_req.operand >> CHUNK_SHIFT);

    // entries never written since reset or freed read as zero
    assign len_eff    = r_vq ? ram_q : '0;
    assign chunk_free = (len_eff == '0);

    // run counter restarts at every page boundary
    always_comb begin
        if (!chunk_free) begin
            run_next = '0;
        end else if (r_chk_idx[CPP_W-1:0] == '0) begin
            run_next = LEN_W'(1);
        end else begin
            run_next = r_run + LEN_W'(1);
        end
    end

    assign run_start = r_chk_idx - IDX_W'(r_need) + IDX_W'(1);

    always_comb begin
        case (r_state)
            S_IDLE:  rd_addr = (i_req.req_type == REQ_RELEASE) ? rel_idx : '0;
            S_SCAN:  rd_addr = r_chk_idx + IDX_W'(1);
            default: rd_addr = r_chk_idx;
        endcase
    end

    assign ram_we    = (r_state == S_WRITE);
    assign set_valid = ram_we;
    assign clr_valid = (r_state == S_FREE);

    ffca_ram #(
        .WIDTH (LEN_W),
        .DEPTH (TOTAL)
    ) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_widx),
        .i_wdata (r_need),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    always_comb begin
        n_state   = r_state;
        n_done    = 1'b0;
        n_rsp     = r_rsp;
        n_need    = r_need;
        n_run     = r_run;
        n_chk_idx = r_chk_idx;
        n_widx    = r_widx;
        n_wcnt    = r_wcnt;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_rsp.block_addr = '0;
                    if (i_req.req_type == REQ_ALLOC) begin
                        if (bad_size) begin
                            n_done       = 1'b1;
                            n_rsp.status = ST_BAD_SIZE;
                        end else begin
                            n_need    = LEN_W'(i_req.operand >> CHUNK_SHIFT);
                            n_run     = '0;
                            n_chk_idx = '0;
                            n_state   = S_SCAN;
                        end
                    end else begin
                        if (rel_out) begin
                            n_done       = 1'b1;
                            n_rsp.status = ST_FREE_REL;
                        end else begin
                            n_chk_idx = rel_idx;
                            n_state   = S_RCHK;
                        end
                    end
                end
            end
            S_SCAN: begin
                n_run     = run_next;
                n_chk_idx = r_chk_idx + IDX_W'(1);
                if (run_next == r_need) begin
                    n_widx           = run_start;
                    n_wcnt           = r_need;
                    n_rsp.block_addr = OP_W'({run_start, {CHUNK_SHIFT{1'b0}}});
                    n_state          = S_WRITE;
                end else if (r_chk_idx == IDX_W'(TOTAL - 1)) begin
                    n_done       = 1'b1;
                    n_rsp.status = ST_NO_ROOM;
                    n_state      = S_IDLE;
                end
            end
            S_WRITE: begin
                n_widx = r_widx + IDX_W'(1);
                n_wcnt = r_wcnt - LEN_W'(1);
                if (r_wcnt == LEN_W'(1)) begin
                    n_done       = 1'b1;
                    n_rsp.status = ST_OK;
                    n_state      = S_IDLE;
                end
            end
            S_RCHK: begin
                if (chunk_free) begin
                    n_done       = 1'b1;
                    n_rsp.status = ST_FREE_REL;
                    n_state      = S_IDLE;
                end else begin
                    n_widx  = r_chk_idx;
                    n_wcnt  = len_eff;
                    n_state = S_FREE;
                end
            end
            S_FREE: begin
                n_widx = r_widx + IDX_W'(1);
                n_wcnt = r_wcnt - LEN_W'(1);
                // freeing stops at the stored length or at the page end
                if ((r_wcnt == LEN_W'(1)) || (r_widx[CPP_W-1:0] == CPP_W'(CPP - 1))) begin
                    n_done       = 1'b1;
                    n_rsp.status = ST_OK;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_valid <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            if (set_valid) begin
                r_valid[r_widx] <= 1'b1;
            end else if (clr_valid) begin
                r_valid[r_widx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp     <= n_rsp;
        r_need    <= n_need;
        r_run     <= n_run;
        r_chk_idx <= n_chk_idx;
        r_widx    <= n_widx;
        r_wcnt    <= n_wcnt;
        r_vq      <= r_valid[rd_addr];
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_done;
    assign o_rsp    = r_rsp;

endmodule

FILE: rtl/core/ffca_checker.sv
// port-level checks of the first-fit chunk allocator, bound to the top level
module ffca_checker
    import ffca_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_strobe,
    input t_rsp o_rsp
);

    // an accepted item either keeps the block busy or answers at once
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_strobe))
        else $error("accepted item neither started nor answered");

    a_done_on_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe)
        else $error("work ended without a response");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("response shown while still busy");

    a_fail_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_rsp.status != ST_OK)) |-> (o_rsp.block_addr == '0))
        else $error("failed request returned a nonzero address");

    a_addr_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_rsp.block_addr[CHUNK_SHIFT-1:0] == '0))
        else $error("block address not chunk aligned");

endmodule

bind first_fit_chunk_allocator ffca_checker u_ffca_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_rsp    (o_rsp)
);

FILE: tb/sv/tb_first_fit_chunk_allocator.sv
// testbench for the first-fit chunk allocator: directed and random requests, scoreboard check
`timescale 1ns / 100ps

module tb_first_fit_chunk_allocator;
    import ffca_pkg::*;

    localparam int TIMEOUT_CYCLES = 200000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int RANDOM_ITEMS   = 400;
    localparam int CALM_ITEMS     = 60;

    // predicts the allocator's answers and holds the answers still owed
    class alloc_scoreboard;
        logic [LEN_W-1:0] chunk_len[TOTAL];
        t_rsp             owed_q[$];
        int               live_starts[$];
        int               errors;
        int               status_count[4];
        int               alloc_items;
        int               release_items;

        function new();
            foreach (chunk_len[i]) chunk_len[i] = '0;
            errors        = 0;
            alloc_items   = 0;
            release_items = 0;
            foreach (status_count[i]) status_count[i] = 0;
        endfunction

        function t_rsp predict(t_req r);
            t_rsp rsp;
            int   size, need, base, idx, len, page_end;
            bit   found, clear;
            rsp.status     = ST_OK;
            rsp.block_addr = '0;
            found          = 1'b0;
            if (r.req_type == REQ_ALLOC) begin
                size = int'(r.operand);
                if (size == 0 || size % CHUNK_BYTES != 0 || size > PAGE_BYTES) begin
                    rsp.status = ST_BAD_SIZE;
                end else begin
                    need = size / CHUNK_BYTES;
                    for (int pg = 0; pg < PAGES && !found; pg++) begin
                        base = pg * CPP;
                        for (int st = 0; st + need <= CPP && !found; st++) begin
                            clear = 1'b1;
                            for (int j = 0; j < need; j++)
                                if (chunk_len[base + st + j] != 0) clear = 1'b0;
                            if (clear) begin
                                for (int j = 0; j < need; j++)
                                    chunk_len[base + st + j] = LEN_W'(need);
                                rsp.block_addr = OP_W'((base + st) * CHUNK_BYTES);
                                live_starts.push_back((base + st) * CHUNK_BYTES);
                                found = 1'b1;
                            end
                        end
                    end
                    if (!found) rsp.status = ST_NO_ROOM;
                end
            end else begin
                if (int'(r.operand) >= ARENA_BYTES) begin
                    rsp.status = ST_FREE_REL;
                end else begin
                    idx = int'(r.operand) / CHUNK_BYTES;
                    len = int'(chunk_len[idx]);
                    if (len == 0) begin
                        rsp.status = ST_FREE_REL;
                    end else begin
                        // freeing is clipped at the end of the addressed chunk's page
                        page_end = (idx / CPP + 1) * CPP;
                        for (int j = 0; j < len && idx + j < page_end; j++)
                            chunk_len[idx + j] = '0;
                    end
                end
            end
            return rsp;
        endfunction

        function void note_request(t_req r);
            t_rsp rsp;
            rsp = predict(r);
            if (r.req_type == REQ_ALLOC) alloc_items++;
            else release_items++;
            status_count[rsp.status]++;
            owed_q.push_back(rsp);
        endfunction

        function void check_response(t_rsp got);
            t_rsp want;
            if (owed_q.size() == 0) begin
                $error("response with no request outstanding: status %0d block_addr %0d",
                       got.status, got.block_addr);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.block_addr !== want.block_addr) begin
                $error("block_addr: expected %0d, got %0d", want.block_addr, got.block_addr);
                errors++;
            end
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_strobe;
    t_rsp o_rsp;

    alloc_scoreboard sb = new();
    int cycle_count = 0;

    first_fit_chunk_allocator dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (i_req),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_rsp    (o_rsp)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == TIMEOUT_CYCLES) begin
            $display("timeout after %0d cycles, %0d answers outstanding",
                     cycle_count, sb.owed_q.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // answers are checked before a new item at the same edge is noted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) sb.check_response(o_rsp);
            if (start && !busy) sb.note_request(i_req);
        end
    end

    function automatic t_req make_req(logic kind, int op);
        t_req r;
        r.req_type = kind;
        r.operand  = OP_W'(op);
        return r;
    endfunction

    function automatic t_req random_request();
        int pick, k, n;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            k = ($urandom_range(0, 3) == 0) ? $urandom_range(1, CPP) : $urandom_range(1, 4);
            return make_req(REQ_ALLOC, k * CHUNK_BYTES);
        end else if (pick < 63) begin
            return make_req(REQ_ALLOC, $urandom_range(0, 16383));
        end else if (pick < 68 || sb.live_starts.size() == 0) begin
            return make_req(REQ_RELEASE, $urandom_range(0, 16383));
        end else begin
            n = $urandom_range(0, sb.live_starts.size() - 1);
            k = sb.live_starts[n];
            if ($urandom_range(0, 4) != 0) sb.live_starts.delete(n);
            // now and then add an offset below two chunks to the block's start
            if ($urandom_range(0, 3) == 0) k = k + $urandom_range(0, 2 * CHUNK_BYTES - 1);
            return make_req(REQ_RELEASE, k % 16384);
        end
    endfunction

    // called at a rising edge; returns at the edge where the item was taken
    task automatic issue(t_req r, int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
    endtask

    initial begin
        t_req directed_q[$];
        int   gap;

        directed_q.push_back(make_req(REQ_ALLOC, 0));
        directed_q.push_back(make_req(REQ_ALLOC, 255));
        directed_q.push_back(make_req(REQ_ALLOC, 4097));
        directed_q.push_back(make_req(REQ_ALLOC, 16383));
        directed_q.push_back(make_req(REQ_ALLOC, 16128));
        directed_q.push_back(make_req(REQ_RELEASE, 0));
        directed_q.push_back(make_req(REQ_ALLOC, 4096));
        directed_q.push_back(make_req(REQ_ALLOC, 256));
        directed_q.push_back(make_req(REQ_ALLOC, 3840));
        directed_q.push_back(make_req(REQ_ALLOC, 4096));
        directed_q.push_back(make_req(REQ_ALLOC, 4096));
        // arena full
        directed_q.push_back(make_req(REQ_ALLOC, 256));
        // last chunk of a whole-page block, clipped at the page end
        directed_q.push_back(make_req(REQ_RELEASE, 16383));
        directed_q.push_back(make_req(REQ_ALLOC, 256));
        // unaligned address selects its chunk
        directed_q.push_back(make_req(REQ_RELEASE, 100));
        directed_q.push_back(make_req(REQ_RELEASE, 0));
        directed_q.push_back(make_req(REQ_ALLOC, 1024));
        directed_q.push_back(make_req(REQ_ALLOC, 768));
        // release from inside a block runs over into the next one
        directed_q.push_back(make_req(REQ_RELEASE, 512));
        directed_q.push_back(make_req(REQ_ALLOC, 512));
        directed_q.push_back(make_req(REQ_RELEASE, 4096));
        directed_q.push_back(make_req(REQ_RELEASE, 12288));
        directed_q.push_back(make_req(REQ_RELEASE, 12287));
        directed_q.push_back(make_req(REQ_ALLOC, 4096));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_q[i]) begin
            gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 18) : 0;
            issue(directed_q[i], gap);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            gap = 0;
            if (n < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(0, 9) < 3)
                gap = $urandom_range(1, 18);
            issue(random_request(), gap);
        end
        start <= 1'b0;

        while (sb.owed_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d allocate and %0d release items in %0d cycles",
                 sb.alloc_items, sb.release_items, cycle_count);
        $display("answers: %0d ok, %0d bad size, %0d no room, %0d release of free chunk",
                 sb.status_count[ST_OK], sb.status_count[ST_BAD_SIZE],
                 sb.status_count[ST_NO_ROOM], sb.status_count[ST_FREE_REL]);
        if (sb.errors == 0 && sb.owed_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/ffca_pkg.sv
rtl/core/ffca_ram.sv
rtl/core/first_fit_chunk_allocator.sv
rtl/core/ffca_checker.sv
tb/sv/tb_first_fit_chunk_allocator.sv
